// ----- rtl/core/jpeg_dqt_marker_parser_top_defines.svh -----
// Assertion macros shared by the DQT marker parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef JPEG_DQT_MARKER_PARSER_TOP_DEFINES_SVH
`define JPEG_DQT_MARKER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JDP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define JDP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/jdp_pkg.sv -----
// Types, codes and constants of the DQT marker parser.
// Depends on nothing; used by the parser, the result queue and the top level.
`default_nettype none

package jdp_pkg;

  localparam int TableEntries   = 64;
  localparam int IdxW           = $clog2(TableEntries);
  localparam int OutDepthDefault = 4;

  localparam logic [7:0] ByteFill     = 8'hFF;
  localparam logic [7:0] ByteSoi      = 8'hD8;
  localparam logic [7:0] MarkerTem    = 8'h01;
  localparam logic [7:0] MarkerRstLo  = 8'hD0;
  localparam logic [7:0] MarkerEoi    = 8'hD9;
  localparam logic [7:0] MarkerDqt    = 8'hDB;
  localparam logic [7:0] MarkerSos    = 8'hDA;
  localparam logic [7:0] MarkerDht    = 8'hC4;
  localparam logic [3:0] NibbleMask   = 4'hF;

  typedef enum logic [3:0] {
    PhHdr0  = 4'd0,
    PhHdr1  = 4'd1,
    PhScan  = 4'd2,
    PhMark  = 4'd3,
    PhDqtLh = 4'd4,
    PhDqtLl = 4'd5,
    PhFinLh = 4'd6,
    PhFinLl = 4'd7,
    PhOthLh = 4'd8,
    PhOthLl = 4'd9,
    PhInfo  = 4'd10,
    PhEntA  = 4'd11,
    PhEntB  = 4'd12,
    PhSkip  = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    StSegment  = 2'd0,
    StNotJpeg  = 2'd1,
    StEndFile  = 2'd2,
    StTruncate = 2'd3
  } status_e;

  typedef enum logic {
    KindEntry  = 1'b0,
    KindFinish = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [3:0]      table_id;
    logic [3:0]      table_precision;
    logic [IdxW-1:0] entry_index;
    logic [15:0]     entry_value;
    logic            table_done;
    status_e         status;
    logic            last;
  } result_t;

  // Results produced by one byte, handed to the output buffer.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    phase_e          phase;
    logic [15:0]     seg_rem;
    logic [7:0]      len_high;
    logic [3:0]      tbl_id;
    logic [3:0]      prec;
    logic [IdxW-1:0] ent_cnt;
    logic [7:0]      val_high;
    logic            finished;
  } pstate_t;

endpackage

`default_nettype wire

// ----- rtl/core/jdp_if.sv -----
// Valid/ready stream interfaces for the byte input and result output.
// Depends on nothing.
`default_nettype none

interface jdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface jdp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  table_id;
  logic [3:0]  table_precision;
  logic [5:0]  entry_index;
  logic [15:0] entry_value;
  logic        table_done;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, kind, table_id, table_precision, entry_index,
                  entry_value, table_done, status, last, input ready);
  modport sink   (input valid, kind, table_id, table_precision, entry_index,
                  entry_value, table_done, status, last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/jdp_parser.sv -----
// Input register and marker/segment state machine of the DQT parser.
// Depends on jdp_pkg and jdp_in_if; feeds jdp_out_buf.
`default_nettype none
`include "jpeg_dqt_marker_parser_top_defines.svh"

module jdp_parser (
  input  wire              clk_i,
  input  wire              rst_ni,
  jdp_in_if.sink           in_i,
  input  wire              room_i,
  output jdp_pkg::push_t   push_o
);

  logic             vld_q, vld_d;
  logic [7:0]       byte_q;
  logic             first_q;
  logic             lastb_q;
  logic             adv;
  jdp_pkg::pstate_t state_q, state_d;
  jdp_pkg::result_t ent_r, fin_r;
  logic             ent_v, fin_v;
  logic [1:0]       n_res;

  assign adv        = vld_q && room_i;
  assign in_i.ready = !vld_q || adv;

  always_comb begin
    vld_d = vld_q;
    if (in_i.valid && in_i.ready) begin
      vld_d = 1'b1;
    end else if (adv) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      first_q <= in_i.first_byte;
      lastb_q <= in_i.last_byte;
    end
  end

  always_comb begin
    jdp_pkg::pstate_t st;
    logic [15:0] len;
    logic [15:0] rem_dec;
    logic [15:0] val;
    logic        done;

    st = state_q;
    if (first_q) begin
      st       = '0;
      st.phase = jdp_pkg::PhHdr0;
    end
    state_d = st;
    ent_v   = 1'b0;
    fin_v   = 1'b0;
    ent_r   = '0;
    fin_r   = '0;
    len     = {st.len_high, byte_q};
    rem_dec = (st.seg_rem != 16'd0) ? st.seg_rem - 16'd1 : st.seg_rem;
    val     = '0;
    done    = 1'b0;

    fin_r.kind   = jdp_pkg::KindFinish;
    fin_r.status = jdp_pkg::StSegment;
    ent_r.kind   = jdp_pkg::KindEntry;
    ent_r.status = jdp_pkg::StSegment;

    // An unused phase code stays silent, like a finished parse.
    if (!st.finished && st.phase <= jdp_pkg::PhSkip) begin
      unique case (st.phase) inside
        jdp_pkg::PhHdr0: begin
          if (byte_q != jdp_pkg::ByteFill) begin
            fin_v             = 1'b1;
            fin_r.status      = jdp_pkg::StNotJpeg;
            state_d.finished  = 1'b1;
          end else begin
            state_d.phase = jdp_pkg::PhHdr1;
          end
        end
        jdp_pkg::PhHdr1: begin
          if (byte_q != jdp_pkg::ByteSoi) begin
            fin_v             = 1'b1;
            fin_r.status      = jdp_pkg::StNotJpeg;
            state_d.finished  = 1'b1;
          end else begin
            state_d.phase = jdp_pkg::PhScan;
          end
        end
        jdp_pkg::PhScan: begin
          if (byte_q == jdp_pkg::ByteFill) state_d.phase = jdp_pkg::PhMark;
        end
        jdp_pkg::PhMark: begin
          // Fill bytes keep the marker prefix open.
          if (byte_q == jdp_pkg::ByteFill) begin
            state_d.phase = jdp_pkg::PhMark;
          end else if (byte_q == jdp_pkg::MarkerTem ||
                       (byte_q >= jdp_pkg::MarkerRstLo && byte_q <= jdp_pkg::MarkerEoi)) begin
            state_d.phase = jdp_pkg::PhScan;
          end else if (byte_q == jdp_pkg::MarkerDqt) begin
            state_d.phase = jdp_pkg::PhDqtLh;
          end else if (byte_q == jdp_pkg::MarkerSos || byte_q == jdp_pkg::MarkerDht) begin
            state_d.phase = jdp_pkg::PhFinLh;
          end else begin
            state_d.phase = jdp_pkg::PhOthLh;
          end
        end
        jdp_pkg::PhDqtLh: begin
          state_d.len_high = byte_q;
          state_d.phase    = jdp_pkg::PhDqtLl;
        end
        jdp_pkg::PhFinLh: begin
          state_d.len_high = byte_q;
          state_d.phase    = jdp_pkg::PhFinLl;
        end
        jdp_pkg::PhOthLh: begin
          state_d.len_high = byte_q;
          state_d.phase    = jdp_pkg::PhOthLl;
        end
        jdp_pkg::PhDqtLl, jdp_pkg::PhFinLl, jdp_pkg::PhOthLl: begin
          // A length below two means an empty segment.
          state_d.seg_rem = (len >= 16'd2) ? len - 16'd2 : 16'd0;
          if (st.phase == jdp_pkg::PhFinLl) begin
            fin_v            = 1'b1;
            fin_r.status     = jdp_pkg::StSegment;
            state_d.finished = 1'b1;
          end else if (state_d.seg_rem == 16'd0) begin
            state_d.phase = jdp_pkg::PhScan;
          end else if (st.phase == jdp_pkg::PhDqtLl) begin
            state_d.phase = jdp_pkg::PhInfo;
          end else begin
            state_d.phase = jdp_pkg::PhSkip;
          end
        end
        jdp_pkg::PhInfo: begin
          state_d.seg_rem = rem_dec;
          state_d.prec    = byte_q[7:4] & jdp_pkg::NibbleMask;
          state_d.tbl_id  = byte_q[3:0] & jdp_pkg::NibbleMask;
          state_d.ent_cnt = '0;
          state_d.phase   = jdp_pkg::PhEntA;
        end
        jdp_pkg::PhEntA, jdp_pkg::PhEntB: begin
          state_d.seg_rem = rem_dec;
          if (st.phase == jdp_pkg::PhEntA && st.prec != 4'd0) begin
            state_d.val_high = byte_q;
            state_d.phase    = jdp_pkg::PhEntB;
          end else begin
            val  = (st.phase == jdp_pkg::PhEntB) ? {st.val_high, byte_q} : {8'd0, byte_q};
            done = (st.ent_cnt == jdp_pkg::IdxW'(jdp_pkg::TableEntries - 1));
            ent_v                 = 1'b1;
            ent_r.table_id        = st.tbl_id;
            ent_r.table_precision = st.prec;
            ent_r.entry_index     = st.ent_cnt;
            ent_r.entry_value     = val;
            ent_r.table_done      = done;
            if (done) begin
              state_d.ent_cnt = '0;
              state_d.phase   = (rem_dec != 16'd0) ? jdp_pkg::PhInfo : jdp_pkg::PhScan;
            end else begin
              state_d.ent_cnt = st.ent_cnt + 1'b1;
              state_d.phase   = jdp_pkg::PhEntA;
            end
          end
        end
        jdp_pkg::PhSkip: begin
          state_d.seg_rem = rem_dec;
          if (rem_dec == 16'd0) state_d.phase = jdp_pkg::PhScan;
        end
        default: begin
          state_d = st;
        end
      endcase

      // End of file: close the parse unless this byte already did.
      if (lastb_q && !state_d.finished) begin
        fin_v            = 1'b1;
        state_d.finished = 1'b1;
        if (state_d.phase == jdp_pkg::PhHdr1) begin
          fin_r.status = jdp_pkg::StNotJpeg;
        end else if (state_d.phase == jdp_pkg::PhEntA || state_d.phase == jdp_pkg::PhEntB) begin
          fin_r.status = jdp_pkg::StTruncate;
        end else begin
          fin_r.status = jdp_pkg::StEndFile;
        end
      end
    end

    // Order the beats: the entry goes before the finish, last marks the final one.
    push_o    = '0;
    n_res     = {1'b0, ent_v} + {1'b0, fin_v};
    if (ent_v) begin
      push_o.r0 = ent_r;
      push_o.r1 = fin_r;
      if (fin_v) push_o.r1.last = 1'b1;
      else       push_o.r0.last = 1'b1;
    end else begin
      push_o.r0      = fin_r;
      push_o.r0.last = 1'b1;
    end
    push_o.n = adv ? n_res : 2'd0;
  end

  // Phase code zero is the wait for the first header byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (adv) begin
      state_q <= state_d;
    end
  end

  `JDP_ASSERT_IMP(a_two_only_on_last, clk_i, rst_ni,
    adv && n_res == 2'd2, lastb_q, "two beats without last byte")
  `JDP_ASSERT_IMP(a_quiet_after_fin, clk_i, rst_ni,
    adv && state_q.finished && !first_q, n_res == 2'd0, "beat after finish")
  `JDP_ASSERT_NXT(a_hold_stalled, clk_i, rst_ni,
    vld_q && !adv, vld_q && $stable(byte_q), "stalled byte lost")

endmodule

`default_nettype wire

// ----- rtl/core/jdp_out_buf.sv -----
// Small result queue between the parser and the output channel.
// Depends on jdp_pkg and jdp_out_if; takes up to two beats per cycle.
`default_nettype none
`include "jpeg_dqt_marker_parser_top_defines.svh"

module jdp_out_buf #(
  parameter int Depth = jdp_pkg::OutDepthDefault
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  jdp_pkg::push_t push_i,
  output logic           room_o,
  jdp_out_if.source      out_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jdp_pkg::result_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]   wr1;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;
  jdp_pkg::result_t  head;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr1    = ptr_inc(wr_ptr_q);
  assign room_o = (count_q <= CntW'(Depth - 2));
  assign pop    = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.n == 2'd1)      wr_ptr_d = wr1;
    else if (push_i.n == 2'd2) wr_ptr_d = ptr_inc(wr1);
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.n) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wr1]      <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head                  = mem_q[rd_ptr_q];
  assign out_o.valid           = (count_q != '0);
  assign out_o.kind            = head.kind;
  assign out_o.table_id        = head.table_id;
  assign out_o.table_precision = head.table_precision;
  assign out_o.entry_index     = head.entry_index;
  assign out_o.entry_value     = head.entry_value;
  assign out_o.table_done      = head.table_done;
  assign out_o.status          = head.status;
  assign out_o.last            = head.last;

  `JDP_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i.n != 2'd0, count_q <= CntW'(Depth - 2), "push without room")
  `JDP_ASSERT_NXT(a_pop_drains, clk_i, rst_ni, pop && push_i.n == 2'd0, count_q == $past(count_q) - 1'b1, "pop count slip")
  `JDP_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth), "queue count over depth")

endmodule

`default_nettype wire

// ----- rtl/core/jpeg_dqt_marker_parser_top.sv -----
// Top level of the JPEG DQT marker parser: input register/parser and result queue.
// Depends on jdp_pkg, jdp_if, jdp_parser and jdp_out_buf.
//
// Usage:
//   in_i carries one file byte per beat with first_byte (restart, new file)
//   and last_byte (final byte). out_o carries result beats: quantization
//   table entries (kind 0) and one finish beat (kind 1) with its status;
//   last marks the final beat caused by a byte.
// Path: a taken byte is held in the input register; once the queue has room,
//   its beats are written into the result queue, and out_o shows the beat
//   at the head of that queue.
// Throughput: one byte per cycle while the queue has room for two beats.
//   A byte that yields two beats (entry plus finish on the final byte)
//   fills two queue slots, and out_o moves one beat a cycle.
// Reset: the parser waits for the first header byte, the queue is empty,
//   the input register holds nothing. No clearing pass is needed.
// Stall: when out_o.ready is low, beats pile up in the queue; once fewer
//   than two slots are free the parser holds its byte and in_i.ready drops
//   for as long as the input register is occupied.
`default_nettype none

module jpeg_dqt_marker_parser_top #(
  parameter int OutDepth = jdp_pkg::OutDepthDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  jdp_in_if.sink    in_i,
  jdp_out_if.source out_o
);

  jdp_pkg::push_t push;
  logic           room;

  // Byte register and parse state machine.
  jdp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push)
  );

  // Result queue; its free space backpressures the parser.
  jdp_out_buf #(
    .Depth (OutDepth)
  ) u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
